[design/udp_session_request_splitter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the UDP session request splitter
// Shared property wrappers clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef UDP_SESSION_REQUEST_SPLITTER_ASSERT_SVH
`define UDP_SESSION_REQUEST_SPLITTER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define USRS_ASSERT_SAME(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("udp_srs assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define USRS_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("udp_srs assertion failed");

`endif

[design/udp_srs_pkg.sv]
// ----------------------------------------------------------------------------
// udp_srs_pkg
// Shared types and constants of the UDP session request splitter.
// ----------------------------------------------------------------------------
package udp_srs_pkg;

  localparam int unsigned SLOT_BITS_DEF = 10;
  localparam int unsigned SLOT_W        = 10;
  localparam int unsigned RES_DEPTH     = 4;
  localparam int unsigned IN_TDATA_W    = 176;
  localparam int unsigned OUT_TDATA_W   = 224;
  localparam int unsigned OPC_MSB       = 47;
  localparam int unsigned OPC_LSB       = 32;

  localparam logic [15:0] OPC_OPEN  = 16'd7;
  localparam logic [15:0] OPC_CLOSE = 16'd8;

  localparam logic IN_KIND_HDR  = 1'b0;
  localparam logic IN_KIND_BEAT = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_BEAT    = 2'd1,
    KIND_SESSION = 2'd2,
    KIND_COUNT   = 2'd3
  } out_kind_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] udp_length;
    logic [63:0] beat_data;
    logic        beat_last;
  } in_item_t;

  typedef struct packed {
    out_kind_e   out_kind;
    logic [31:0] out_src_ip;
    logic [31:0] out_dest_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dest_port;
    logic [15:0] out_length;
    logic [63:0] out_data;
    logic        out_beat_last;
    logic        session_open;
    logic [SLOT_W-1:0] session_slot;
    logic [31:0] packet_count;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic en0;
    logic en1;
  } push_t;

  typedef struct packed {
    logic       room2;
    logic [2:0] cnt;
  } fifo_stat_t;

endpackage

[design/udp_srs_core.sv]
// ----------------------------------------------------------------------------
// udp_srs_core
// Input register, packet phase tracking and result generation.
// ----------------------------------------------------------------------------
module udp_srs_core #(
  parameter int unsigned SLOT_BITS = udp_srs_pkg::SLOT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  udp_srs_pkg::in_item_t   in_item_i,
  input  udp_srs_pkg::fifo_stat_t stat_i,
  output udp_srs_pkg::push_t      push_o,
  output udp_srs_pkg::res_t       res0_o,
  output udp_srs_pkg::res_t       res1_o
);
  import udp_srs_pkg::*;

  localparam logic [63:0] SlotMask = (64'd1 << SLOT_BITS) - 64'd1;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_OPC,
    PH_SLOT,
    PH_DRAIN
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        valid_q;
  in_item_t    item_q;
  logic [31:0] src_ip_q, src_ip_d;
  logic [31:0] dest_ip_q, dest_ip_d;
  logic [15:0] src_port_q, src_port_d;
  logic [15:0] dest_port_q, dest_port_d;
  logic [15:0] length_q, length_d;
  logic        is_open_q, is_open_d;
  logic [31:0] count_q, count_d;
  logic        consume;
  logic [15:0] opcode;
  logic [63:0] slot_full;

  assign consume    = valid_q && stat_i.room2;
  assign in_ready_o = !valid_q || stat_i.room2;
  assign opcode     = item_q.beat_data[OPC_MSB:OPC_LSB];
  assign slot_full  = item_q.beat_data & SlotMask;

  always_comb begin
    phase_d     = phase_q;
    src_ip_d    = src_ip_q;
    dest_ip_d   = dest_ip_q;
    src_port_d  = src_port_q;
    dest_port_d = dest_port_q;
    length_d    = length_q;
    is_open_d   = is_open_q;
    count_d     = count_q;
    push_o      = '0;
    res0_o      = '0;
    res1_o      = '0;
    if (consume) begin
      unique case (phase_q)
        PH_HDR: begin
          if (item_q.kind == IN_KIND_HDR) begin
            src_ip_d    = item_q.dest_ip;
            dest_ip_d   = item_q.src_ip;
            src_port_d  = item_q.dport;
            dest_port_d = item_q.sport;
            length_d    = item_q.udp_length;
            phase_d     = PH_OPC;
          end
        end
        PH_OPC: begin
          if (item_q.kind == IN_KIND_BEAT) begin
            if (opcode == OPC_OPEN || opcode == OPC_CLOSE) begin
              res0_o.out_kind      = KIND_HEADER;
              res0_o.out_src_ip    = src_ip_q;
              res0_o.out_dest_ip   = dest_ip_q;
              res0_o.out_src_port  = src_port_q;
              res0_o.out_dest_port = dest_port_q;
              res0_o.out_length    = length_q;
              res1_o.out_kind      = KIND_BEAT;
              res1_o.out_data      = item_q.beat_data;
              res1_o.out_beat_last = item_q.beat_last;
              res1_o.run_last      = 1'b1;
              push_o.en0           = 1'b1;
              push_o.en1           = 1'b1;
              is_open_d            = (opcode == OPC_OPEN);
              phase_d              = PH_SLOT;
            end else begin
              count_d             = count_q + 32'd1;
              res0_o.out_kind     = KIND_COUNT;
              res0_o.packet_count = count_d;
              res0_o.run_last     = 1'b1;
              push_o.en0          = 1'b1;
              phase_d             = item_q.beat_last ? PH_HDR : PH_DRAIN;
            end
          end
        end
        PH_SLOT: begin
          if (item_q.kind == IN_KIND_BEAT) begin
            res0_o.out_kind      = KIND_SESSION;
            res0_o.session_open  = is_open_q;
            res0_o.session_slot  = slot_full[SLOT_W-1:0];
            res1_o.out_kind      = KIND_BEAT;
            res1_o.out_data      = is_open_q ? item_q.beat_data
                                             : (item_q.beat_data & ~SlotMask);
            res1_o.out_beat_last = 1'b1;
            res1_o.run_last      = 1'b1;
            push_o.en0           = 1'b1;
            push_o.en1           = 1'b1;
            phase_d              = item_q.beat_last ? PH_HDR : PH_DRAIN;
          end
        end
        PH_DRAIN: begin
          if (item_q.kind == IN_KIND_BEAT && item_q.beat_last) begin
            phase_d = PH_HDR;
          end
        end
        default: phase_d = PH_HDR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR;
      valid_q     <= 1'b0;
      src_ip_q    <= '0;
      dest_ip_q   <= '0;
      src_port_q  <= '0;
      dest_port_q <= '0;
      length_q    <= '0;
      is_open_q   <= 1'b0;
      count_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      src_ip_q    <= src_ip_d;
      dest_ip_q   <= dest_ip_d;
      src_port_q  <= src_port_d;
      dest_port_q <= dest_port_d;
      length_q    <= length_d;
      is_open_q   <= is_open_d;
      count_q     <= count_d;
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  // Hold the input beat until the core consumes it, which waits for room for two results in the result queue.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

[design/udp_srs_res_fifo.sv]
// ----------------------------------------------------------------------------
// udp_srs_res_fifo
// Small result queue taking up to two results per cycle, draining one while the output is ready.
// ----------------------------------------------------------------------------
module udp_srs_res_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  udp_srs_pkg::push_t      push_i,
  input  udp_srs_pkg::res_t       res0_i,
  input  udp_srs_pkg::res_t       res1_i,
  output udp_srs_pkg::fifo_stat_t stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output udp_srs_pkg::res_t       out_res_o
);
  import udp_srs_pkg::*;

  localparam int unsigned PtrW = $clog2(RES_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  res_t            mem_q [RES_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] wr_ptr1;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign wr_ptr1     = wr_ptr_q + PtrW'(1);
  assign wr_ptr_d    = wr_ptr_q + PtrW'(push_i.en0) + PtrW'(push_i.en1);
  assign cnt_d       = cnt_q + CntW'(push_i.en0) + CntW'(push_i.en1) - CntW'(pop);

  always_comb begin
    stat_o       = '0;
    stat_o.room2 = (cnt_q <= CntW'(RES_DEPTH - 2));
    stat_o.cnt   = 3'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.en0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_i.en1) begin
      mem_q[wr_ptr1] <= res1_i;
    end
  end

endmodule

[design/udp_session_request_splitter.sv]
// Path: a taken beat is held in the input register item_q, its results are written
// into the result queue, and they leave the result queue in order.
// Throughput: one input beat per cycle while the queue has room for two results;
// results drain one per cycle while m_axis_tready is high.
// Reset: rst_ni low clears phase, saved header, packet count and the result queue.
// ----------------------------------------------------------------------------
// udp_session_request_splitter
// Splits received UDP packets into reply headers, reply beats, session
// requests and non-session packet count updates.
// ----------------------------------------------------------------------------
`include "udp_session_request_splitter_assert.svh"

module udp_session_request_splitter #(
  parameter int unsigned SLOT_BITS = udp_srs_pkg::SLOT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // src_ip, dest_ip, sport, dport, udp_length, beat_data
  input  logic [udp_srs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_src_ip, out_dest_ip, out_src_port, out_dest_port, out_length,
  // out_data, out_beat_last, session_open, session_slot, packet_count, zero pad
  output logic [udp_srs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // out_kind
  output logic [1:0]                          m_axis_tuser,
  // run_last
  output logic                                m_axis_tlast
);
  import udp_srs_pkg::*;

  in_item_t   in_item;
  push_t      push;
  res_t       res0;
  res_t       res1;
  res_t       out_res;
  fifo_stat_t stat;

  always_comb begin
    in_item            = '0;
    in_item.kind       = s_axis_tuser;
    in_item.src_ip     = s_axis_tdata[31:0];
    in_item.dest_ip    = s_axis_tdata[63:32];
    in_item.sport      = s_axis_tdata[79:64];
    in_item.dport      = s_axis_tdata[95:80];
    in_item.udp_length = s_axis_tdata[111:96];
    in_item.beat_data  = s_axis_tdata[175:112];
    in_item.beat_last  = s_axis_tlast;
  end

  udp_srs_core #(
    .SLOT_BITS(SLOT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .stat_i     (stat),
    .push_o     (push),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  udp_srs_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tuser = out_res.out_kind;
  assign m_axis_tlast = out_res.run_last;
  assign m_axis_tdata = {4'b0000,
                         out_res.packet_count,
                         out_res.session_slot,
                         out_res.session_open,
                         out_res.out_beat_last,
                         out_res.out_data,
                         out_res.out_length,
                         out_res.out_dest_port,
                         out_res.out_src_port,
                         out_res.out_dest_ip,
                         out_res.out_src_ip};

  `USRS_ASSERT_SAME(a_cnt_bound, 1'b1, stat.cnt <= 3'(RES_DEPTH))
  `USRS_ASSERT_SAME(a_pair_order, push.en1, push.en0)
  `USRS_ASSERT_SAME(a_count_last, m_axis_tvalid && m_axis_tuser == KIND_COUNT, m_axis_tlast)
  `USRS_ASSERT_SAME(a_hdr_not_last, m_axis_tvalid && m_axis_tuser == KIND_HEADER, !m_axis_tlast)

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UDP session request splitter testbench
// Streams headers and payload beats into the splitter under random source
// gaps and sink stalls, predicts reply headers, reply beats, session requests
// and packet count updates, and checks every output beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import udp_srs_pkg::*;

  typedef enum logic [1:0] {
    ST_HEADER = 2'd0,
    ST_OPCODE = 2'd1,
    ST_SLOT   = 2'd2,
    ST_DRAIN  = 2'd3
  } rx_stage_e;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned ITEM_TARGET = 950;
  localparam logic [63:0] SLOT_MASK   = (64'd1 << SLOT_BITS_DEF) - 64'd1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  logic     drv_valid = 1'b0;
  in_item_t drv_item  = '0;
  logic     rx_ready  = 1'b0;

  in_item_t pend_q[$];
  res_t     reply_q[$];

  // Predicted splitter state
  rx_stage_e   stage;
  logic [31:0] hdr_src_ip;
  logic [31:0] hdr_dest_ip;
  logic [15:0] hdr_src_port;
  logic [15:0] hdr_dest_port;
  logic [15:0] hdr_length;
  logic [15:0] cur_opcode;
  logic [31:0] pkt_count;

  int unsigned err_cnt  = 0;
  int unsigned idle_cyc = 0;
  int unsigned in_gap   = 0;
  int unsigned in_calm  = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm  = 0;

  udp_session_request_splitter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (drv_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  ({drv_item.beat_data, drv_item.udp_length, drv_item.dport,
                     drv_item.sport, drv_item.dest_ip, drv_item.src_ip}),
    .s_axis_tuser  (drv_item.kind),
    .s_axis_tlast  (drv_item.beat_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap(input int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm != 0 || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_header(input int unsigned style);
    in_item_t it;
    it.kind       = IN_KIND_HDR;
    it.src_ip     = $urandom();
    it.dest_ip    = $urandom();
    it.sport      = 16'($urandom());
    it.dport      = 16'($urandom());
    it.udp_length = 16'($urandom());
    it.beat_data  = rand_word();
    it.beat_last  = 1'($urandom_range(0, 1));
    if (style == 1) begin
      {it.src_ip, it.dest_ip, it.sport, it.dport, it.udp_length} = '0;
    end else if (style == 2) begin
      {it.src_ip, it.dest_ip, it.sport, it.dport, it.udp_length} = '1;
    end
    return it;
  endfunction

  function automatic in_item_t make_beat(input logic [63:0] data, input logic last);
    in_item_t it;
    it           = make_header(0);
    it.kind      = IN_KIND_BEAT;
    it.beat_data = data;
    it.beat_last = last;
    return it;
  endfunction

  function automatic logic [63:0] opcode_word(input logic [15:0] opc);
    logic [63:0] d;
    d = rand_word();
    d[OPC_MSB:OPC_LSB] = opc;
    return d;
  endfunction

  task automatic add_packet(input logic [15:0] opc, input int unsigned n_beats);
    logic [63:0] d;
    pend_q.push_back(make_header($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0));
    for (int unsigned i = 0; i < n_beats; i++) begin
      d = (i == 0) ? opcode_word(opc) : rand_word();
      if (i == 1 && $urandom_range(0, 3) == 0)
        d[SLOT_W-1:0] = $urandom_range(0, 1) ? '1 : '0;
      pend_q.push_back(make_beat(d, i == n_beats - 1));
    end
  endtask

  function automatic logic [15:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return OPC_OPEN;
    if (r < 80) return OPC_CLOSE;
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return OPC_OPEN - 16'd1;
      3: return OPC_CLOSE + 16'd1;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void predict(input in_item_t it);
    res_t r;
    case (stage)
      ST_HEADER: begin
        if (it.kind == IN_KIND_HDR) begin
          hdr_src_ip    = it.dest_ip;
          hdr_dest_ip   = it.src_ip;
          hdr_src_port  = it.dport;
          hdr_dest_port = it.sport;
          hdr_length    = it.udp_length;
          stage         = ST_OPCODE;
        end
      end
      ST_OPCODE: begin
        if (it.kind == IN_KIND_BEAT) begin
          cur_opcode = it.beat_data[OPC_MSB:OPC_LSB];
          if (cur_opcode == OPC_OPEN || cur_opcode == OPC_CLOSE) begin
            r               = '0;
            r.out_kind      = KIND_HEADER;
            r.out_src_ip    = hdr_src_ip;
            r.out_dest_ip   = hdr_dest_ip;
            r.out_src_port  = hdr_src_port;
            r.out_dest_port = hdr_dest_port;
            r.out_length    = hdr_length;
            reply_q.push_back(r);
            r               = '0;
            r.out_kind      = KIND_BEAT;
            r.out_data      = it.beat_data;
            r.out_beat_last = it.beat_last;
            r.run_last      = 1'b1;
            reply_q.push_back(r);
            stage           = ST_SLOT;
          end else begin
            pkt_count      = pkt_count + 32'd1;
            r              = '0;
            r.out_kind     = KIND_COUNT;
            r.packet_count = pkt_count;
            r.run_last     = 1'b1;
            reply_q.push_back(r);
            stage          = it.beat_last ? ST_HEADER : ST_DRAIN;
          end
        end
      end
      ST_SLOT: begin
        if (it.kind == IN_KIND_BEAT) begin
          r              = '0;
          r.out_kind     = KIND_SESSION;
          r.session_open = (cur_opcode == OPC_OPEN);
          r.session_slot = it.beat_data[SLOT_W-1:0];
          reply_q.push_back(r);
          r               = '0;
          r.out_kind      = KIND_BEAT;
          r.out_data      = (cur_opcode == OPC_OPEN) ? it.beat_data
                                                     : (it.beat_data & ~SLOT_MASK);
          r.out_beat_last = 1'b1;
          r.run_last      = 1'b1;
          reply_q.push_back(r);
          stage           = it.beat_last ? ST_HEADER : ST_DRAIN;
        end
      end
      default: begin
        if (it.kind == IN_KIND_BEAT && it.beat_last) stage = ST_HEADER;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_reply();
    res_t want;
    if (reply_q.size() == 0) begin
      $error("unexpected beat: out_kind %0d", m_axis_tuser);
      err_cnt++;
    end else begin
      want = reply_q.pop_front();
      check_field("out_kind",      64'(want.out_kind),      64'(m_axis_tuser));
      check_field("out_src_ip",    64'(want.out_src_ip),    64'(m_axis_tdata[31:0]));
      check_field("out_dest_ip",   64'(want.out_dest_ip),   64'(m_axis_tdata[63:32]));
      check_field("out_src_port",  64'(want.out_src_port),  64'(m_axis_tdata[79:64]));
      check_field("out_dest_port", 64'(want.out_dest_port), 64'(m_axis_tdata[95:80]));
      check_field("out_length",    64'(want.out_length),    64'(m_axis_tdata[111:96]));
      check_field("out_data",      want.out_data,           m_axis_tdata[175:112]);
      check_field("out_beat_last", 64'(want.out_beat_last), 64'(m_axis_tdata[176]));
      check_field("session_open",  64'(want.session_open),  64'(m_axis_tdata[177]));
      check_field("session_slot",  64'(want.session_slot),  64'(m_axis_tdata[187:178]));
      check_field("packet_count",  64'(want.packet_count),  64'(m_axis_tdata[219:188]));
      check_field("zero_pad",      64'd0,                   64'(m_axis_tdata[223:220]));
      check_field("run_last",      64'(want.run_last),      64'(m_axis_tlast));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      in_gap    <= 0;
      in_calm   <= 0;
    end else begin
      if (drv_valid && s_axis_tready) predict(drv_item);
      if (!drv_valid || s_axis_tready) begin
        if (in_gap != 0) begin
          drv_valid <= 1'b0;
          in_gap    <= in_gap - 1;
        end else if (pend_q.size() != 0) begin
          drv_item  <= pend_q.pop_front();
          drv_valid <= 1'b1;
          in_gap    <= pick_gap(in_calm);
          in_calm   <= (in_calm != 0) ? in_calm - 1
                     : ($urandom_range(0, 49) == 0 ? $urandom_range(20, 80) : 0);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready  <= 1'b0;
      out_stall <= 0;
      out_calm  <= 0;
    end else begin
      if (m_axis_tvalid && rx_ready) check_reply();
      out_calm <= (out_calm != 0) ? out_calm - 1
                : ($urandom_range(0, 99) == 0 ? $urandom_range(30, 120) : 0);
      if (out_stall != 0) begin
        rx_ready  <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        rx_ready  <= 1'b1;
        out_stall <= ($urandom_range(0, 3) == 0) ? pick_gap(out_calm) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((drv_valid && s_axis_tready) || (m_axis_tvalid && rx_ready) || !rst_ni) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    stage         = ST_HEADER;
    hdr_src_ip    = '0;
    hdr_dest_ip   = '0;
    hdr_src_port  = '0;
    hdr_dest_port = '0;
    hdr_length    = '0;
    cur_opcode    = '0;
    pkt_count     = '0;

    // stray beat before any header
    pend_q.push_back(make_beat('1, 1'b1));
    // open with zero header, stray header mid-packet, full-width slot
    pend_q.push_back(make_header(1));
    pend_q.push_back(make_beat(64'h0000_0007_0000_0000, 1'b0));
    pend_q.push_back(make_header(2));
    pend_q.push_back(make_beat('1, 1'b1));
    // close with ones header, then drain
    pend_q.push_back(make_header(2));
    pend_q.push_back(make_beat(64'hffff_0008_ffff_ffff, 1'b0));
    pend_q.push_back(make_beat('1, 1'b0));
    pend_q.push_back(make_beat('0, 1'b0));
    pend_q.push_back(make_beat('1, 1'b1));
    // non-session opcodes
    pend_q.push_back(make_header(0));
    pend_q.push_back(make_beat(64'h0, 1'b1));
    pend_q.push_back(make_header(0));
    pend_q.push_back(make_beat(64'h0000_ffff_0000_0000, 1'b0));
    pend_q.push_back(make_beat(rand_word(), 1'b1));
    // session opcode on a last beat takes the next beat as its slot
    pend_q.push_back(make_header(0));
    pend_q.push_back(make_beat(opcode_word(OPC_OPEN), 1'b1));
    pend_q.push_back(make_beat(rand_word(), 1'b1));
    pend_q.push_back(make_header(0));
    pend_q.push_back(make_beat(opcode_word(OPC_CLOSE), 1'b1));
    pend_q.push_back(make_header(0));
    pend_q.push_back(make_header(0));
    pend_q.push_back(make_beat(opcode_word(OPC_CLOSE + 16'd1), 1'b1));

    while (pend_q.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0: pend_q.push_back(make_beat(rand_word(), 1'($urandom_range(0, 1))));
        1: pend_q.push_back(make_header(0));
        2: add_packet($urandom_range(0, 1) ? OPC_OPEN : OPC_CLOSE, 1);
        default: begin
          if (pick_opcode() inside {OPC_OPEN, OPC_CLOSE})
            add_packet($urandom_range(0, 1) ? OPC_OPEN : OPC_CLOSE,
                       $urandom_range(0, 2) == 0 ? $urandom_range(3, 5) : 2);
          else
            add_packet(pick_opcode(), $urandom_range(1, 3));
        end
      endcase
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || drv_valid || reply_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/udp_srs_pkg.sv
design/udp_srs_core.sv
design/udp_srs_res_fifo.sv
design/udp_session_request_splitter.sv
tb/sv/testbench.sv
